FILE: hw/rtl/context_cache_with_page_translation_assert.svh
// assertion macros for the context cache
`ifndef CONTEXT_CACHE_WITH_PAGE_TRANSLATION_ASSERT_SVH
`define CONTEXT_CACHE_WITH_PAGE_TRANSLATION_ASSERT_SVH

`ifndef ASSERT_OFF
`define CCPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define CCPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CCPT_ASSERT_IMP(lbl, ante, cons)
`define CCPT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/ccpt_pkg.sv
package ccpt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int PAGE_SLOTS_DEF = 1024;
  localparam int PAGE_SHIFT     = 12;

  localparam int KEY_W  = 24;
  localparam int DATA_W = 64;
  localparam int TAG_W  = 8;
  localparam int VA_W   = 37;
  localparam int ES_W   = 13;
  localparam int BASE_W = 32;
  localparam int CFG_W  = 32;
  localparam int LFSR_W = 16;

  localparam logic [LFSR_W-1:0] LFSR_RESET       = 16'hACE1;
  localparam logic [ES_W-1:0]   ENTRY_SIZE_RESET = 13'd64;
  localparam logic [11:0]       OFF_MASK         = 12'hfff;

  localparam logic [0:0] CFG_ICM_BASE   = 1'b0;
  localparam logic [0:0] CFG_ENTRY_SIZE = 1'b1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_MAP   = 2'd3
  } req_type_t;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_DMA   = 3'd1;
  localparam logic [2:0] KIND_WB    = 3'd2;
  localparam logic [2:0] KIND_BUSY  = 3'd3;
  localparam logic [2:0] KIND_RANGE = 3'd4;

  typedef struct packed {
    logic              hit;
    logic              has_free;
  } lookup_t;

  typedef struct packed {
    logic mul_en;
    logic rd_en;
    logic map_en;
  } xlat_ctl_t;

  typedef struct packed {
    logic in_range;
    logic map_ok;
  } xlat_stat_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [63:0]       addr;
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  entry;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } res_t;

endpackage

FILE: hw/rtl/context_cache_with_page_translation.sv
// Context entry cache with page translation.
// Input words on in_* (valid/ready): read, write, DMA fill response or page map.
// Results on out_* (valid/ready), one or two per input word; out_last marks
// the final one. Writes that hit or find a free slot, maps in range and
// fills with no miss pending give no result.
// Configuration: cfg_we with cfg_index 0 sets icm_base, 1 sets entry_size.
// Only one word is in flight. A hit, a busy answer, a map range error or a
// fill that needs no eviction is answered without translation; a read miss, a
// read range error or an eviction passes lookup and multiply, page table
// read and address add, and a fill with eviction gives two results.
// A word with no result returns the block to idle after its lookup. The slot
// data and page table sit in registered-read memories; the sequencer walks
// lookup, translation and write-back one step a cycle unless it waits on the
// output register. After an eviction the next word waits for the new victim.
// Reset (rst_n low, synchronous) empties the cache, drops a pending miss and
// reloads the victim LFSR; no clearing pass is needed.
// A result waits in the output register while out_ready is low; the block
// stalls only when it needs to place the next result.
`include "context_cache_with_page_translation_assert.svh"

module context_cache_with_page_translation #(
  parameter int CAPACITY   = ccpt_pkg::CAPACITY_DEF,
  parameter int PAGE_SLOTS = ccpt_pkg::PAGE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [ccpt_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [ccpt_pkg::KEY_W-1:0]  in_res_index,
  input  logic [ccpt_pkg::DATA_W-1:0] in_entry_data,
  input  logic [ccpt_pkg::TAG_W-1:0]  in_req_tag,
  input  logic [31:0]                 in_icm_vaddr,
  input  logic [63:0]                 in_icm_paddr,
  input  logic                        in_map_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_res_kind,
  output logic [63:0]                 out_res_addr,
  output logic [ccpt_pkg::DATA_W-1:0] out_res_data,
  output logic [ccpt_pkg::KEY_W-1:0]  out_res_entry,
  output logic [ccpt_pkg::TAG_W-1:0]  out_res_tag,
  output logic                        out_last
);
  import ccpt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_TR1,
    S_TR2,
    S_RDAT,
    S_EMIT
  } state_t;

  state_t st_r, st_nxt;

  logic [BASE_W-1:0] icm_base_r;
  logic [ES_W-1:0]   entry_size_r;

  req_type_t         typ_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] dat_r;
  logic [TAG_W-1:0]  tag_r;
  logic [31:0]       vaddr_r;
  logic [63:0]       paddr_r;
  logic              map_last_r;

  logic              miss_pending_r;
  logic [TAG_W-1:0]  pending_tag_r;
  logic [IDX_W-1:0]  slot_r;
  logic [KEY_W-1:0]  vkey_r;
  logic [TAG_W-1:0]  rtag_r;
  res_t              pend_r, pend_nxt;
  res_t              out_r, res;
  logic              out_valid_r;

  lookup_t           lk;
  logic [IDX_W-1:0]  hit_idx, free_idx, victim_idx;
  logic [KEY_W-1:0]  victim_key, xkey;
  logic              victim_ok;
  logic              tw_en, dw_en, lstep;
  logic [IDX_W-1:0]  w_idx;
  logic [IDX_W-1:0]  dr_idx;
  logic [DATA_W-1:0] dw_data;
  logic [DATA_W-1:0] dram_rdata;
  xlat_ctl_t         xctl;
  xlat_stat_t        xs;
  logic [63:0]       xpaddr;
  logic              emit, out_free, accept;
  logic              pend_load, pset, pclr;

  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE) && victim_ok;
  assign out_free = !out_valid_r || out_ready;

  assign xkey   = (typ_r == REQ_READ) ? key_r : victim_key;
  assign dr_idx = lk.hit ? hit_idx : victim_idx;

  assign xctl.mul_en = (st_r == S_LOOK);
  assign xctl.rd_en  = (st_r == S_TR1);
  assign xctl.map_en = (st_r == S_LOOK) && (typ_r == REQ_MAP);

  always_comb begin
    st_nxt    = st_r;
    emit      = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    tw_en     = 1'b0;
    dw_en     = 1'b0;
    w_idx     = free_idx;
    dw_data   = dat_r;
    lstep     = 1'b0;
    pend_load = 1'b0;
    pend_nxt  = '0;
    pend_nxt.last = 1'b1;
    pset      = 1'b0;
    pclr      = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        unique case (typ_r)
          REQ_READ: begin
            if (miss_pending_r) begin
              pend_load      = 1'b1;
              pend_nxt.kind  = KIND_BUSY;
              pend_nxt.entry = key_r;
              pend_nxt.tag   = tag_r;
              st_nxt         = S_EMIT;
            end else if (lk.hit) begin
              st_nxt = S_RDAT;
            end else begin
              st_nxt = S_TR1;
            end
          end
          REQ_WRITE: begin
            if (lk.hit) begin
              dw_en  = 1'b1;
              w_idx  = hit_idx;
              st_nxt = S_IDLE;
            end else if (lk.has_free) begin
              dw_en  = 1'b1;
              tw_en  = 1'b1;
              st_nxt = S_IDLE;
            end else begin
              st_nxt = S_TR1;
            end
          end
          REQ_FILL: begin
            if (!miss_pending_r) begin
              st_nxt = S_IDLE;
            end else begin
              pclr = 1'b1;
              if (lk.hit) begin
                st_nxt = S_RDAT;
              end else if (lk.has_free) begin
                dw_en          = 1'b1;
                tw_en          = 1'b1;
                pend_load      = 1'b1;
                pend_nxt.kind  = KIND_DATA;
                pend_nxt.data  = dat_r;
                pend_nxt.entry = key_r;
                pend_nxt.tag   = pending_tag_r;
                st_nxt         = S_EMIT;
              end else begin
                st_nxt = S_TR1;
              end
            end
          end
          REQ_MAP: begin
            if (xs.map_ok) begin
              st_nxt = S_IDLE;
            end else begin
              pend_load     = 1'b1;
              pend_nxt.kind = KIND_RANGE;
              st_nxt        = S_EMIT;
            end
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_TR1: begin
        st_nxt = S_TR2;
      end
      S_TR2: begin
        if (out_free) begin
          emit = 1'b1;
          if (typ_r == REQ_READ) begin
            res.kind  = xs.in_range ? KIND_DMA : KIND_RANGE;
            res.addr  = xs.in_range ? xpaddr : 64'd0;
            res.entry = key_r;
            res.tag   = xs.in_range ? tag_r : '0;
            pset      = xs.in_range;
            st_nxt    = S_IDLE;
          end else begin
            res.kind  = xs.in_range ? KIND_WB : KIND_RANGE;
            res.addr  = xs.in_range ? xpaddr : 64'd0;
            res.data  = dram_rdata;
            res.entry = vkey_r;
            res.last  = (typ_r == REQ_WRITE);
            tw_en     = 1'b1;
            dw_en     = 1'b1;
            w_idx     = slot_r;
            lstep     = 1'b1;
            if (typ_r == REQ_FILL) begin
              pend_load      = 1'b1;
              pend_nxt.kind  = KIND_DATA;
              pend_nxt.data  = dat_r;
              pend_nxt.entry = key_r;
              pend_nxt.tag   = pending_tag_r;
              st_nxt         = S_EMIT;
            end else begin
              st_nxt = S_IDLE;
            end
          end
        end
      end
      S_RDAT: begin
        if (out_free) begin
          emit      = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = dram_rdata;
          res.entry = key_r;
          res.tag   = rtag_r;
          st_nxt    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit   = 1'b1;
          res    = pend_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      icm_base_r     <= '0;
      entry_size_r   <= ENTRY_SIZE_RESET;
      miss_pending_r <= 1'b0;
      pending_tag_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ICM_BASE:   icm_base_r   <= cfg_data[BASE_W-1:0];
          CFG_ENTRY_SIZE: entry_size_r <= cfg_data[ES_W-1:0];
          default: ;
        endcase
      end
      if (pset) begin
        miss_pending_r <= 1'b1;
        pending_tag_r  <= tag_r;
      end else if (pclr) begin
        miss_pending_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      typ_r      <= req_type_t'(in_req_type);
      key_r      <= in_res_index;
      dat_r      <= in_entry_data;
      tag_r      <= in_req_tag;
      vaddr_r    <= in_icm_vaddr;
      paddr_r    <= in_icm_paddr;
      map_last_r <= in_map_last;
    end
    if (st_r == S_LOOK) begin
      slot_r <= victim_idx;
      vkey_r <= victim_key;
      rtag_r <= (typ_r == REQ_READ) ? tag_r : pending_tag_r;
    end
    if (pend_load) begin
      pend_r <= pend_nxt;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  ccpt_tags #(
    .CAPACITY(CAPACITY)
  ) u_tags (
    .clk       (clk),
    .rst_n     (rst_n),
    .lk_key    (key_r),
    .lk        (lk),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .victim_idx(victim_idx),
    .victim_key(victim_key),
    .victim_ok (victim_ok),
    .wr_en     (tw_en),
    .wr_idx    (w_idx),
    .wr_key    (key_r),
    .step      (lstep)
  );

  ccpt_xlat #(
    .PAGE_SLOTS(PAGE_SLOTS)
  ) u_xlat (
    .clk       (clk),
    .ctl       (xctl),
    .key       (xkey),
    .entry_size(entry_size_r),
    .icm_base  (icm_base_r),
    .map_vaddr (vaddr_r),
    .map_paddr (paddr_r),
    .stat      (xs),
    .paddr     (xpaddr)
  );

  ccpt_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_data (
    .clk  (clk),
    .we   (dw_en),
    .waddr(w_idx),
    .wdata(dw_data),
    .re   (st_r == S_LOOK),
    .raddr(dr_idx),
    .rdata(dram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_res_kind  = out_r.kind;
  assign out_res_addr  = out_r.addr;
  assign out_res_data  = out_r.data;
  assign out_res_entry = out_r.entry;
  assign out_res_tag   = out_r.tag;
  assign out_last      = out_r.last || (map_last_r && 1'b0);

  `CCPT_ASSERT_NXT(a_accept_look, accept, st_r == S_LOOK)
  `CCPT_ASSERT_IMP(a_pend_from_read, $rose(miss_pending_r), $past(typ_r) == REQ_READ)
  `CCPT_ASSERT_IMP(a_evict_only_full, (st_r == S_TR2) && (typ_r != REQ_READ), !lk.has_free)
  `CCPT_ASSERT_IMP(a_emit_has_room, emit, !out_valid_r || out_ready)

endmodule

FILE: hw/rtl/ccpt_ram.sv
module ccpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: hw/rtl/ccpt_tags.sv
module ccpt_tags #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ccpt_pkg::KEY_W-1:0]  lk_key,
  output ccpt_pkg::lookup_t           lk,
  output logic [$clog2(CAPACITY)-1:0] hit_idx,
  output logic [$clog2(CAPACITY)-1:0] free_idx,
  output logic [$clog2(CAPACITY)-1:0] victim_idx,
  output logic [ccpt_pkg::KEY_W-1:0]  victim_key,
  output logic                        victim_ok,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_idx,
  input  logic [ccpt_pkg::KEY_W-1:0]  wr_key,
  input  logic                        step
);
  import ccpt_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int SH      = LFSR_W + IDX_W;
  localparam int RECIP_W = 18;
  localparam int PROD_W  = LFSR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SH + CAPACITY - 1) / CAPACITY);

  logic [KEY_W-1:0]  keys_r [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt, lfsr_d_r;
  logic [PROD_W-1:0] prod_r, prod_sh;
  logic [LFSR_W-1:0] quot, rem;
  logic [IDX_W-1:0]  victim_r;
  logic [1:0]        settle_r;

  always_comb begin
    lk.hit      = 1'b0;
    lk.has_free = 1'b0;
    hit_idx     = '0;
    free_idx    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (valid_r[i] && keys_r[i] == lk_key) begin
        lk.hit  = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        lk.has_free = 1'b1;
        free_idx    = IDX_W'(i);
      end
    end
  end

  // lfsr mod capacity through a reciprocal multiply
  assign lfsr_nxt = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_W-1:1]};
  assign prod_sh  = prod_r >> SH;
  assign quot     = prod_sh[LFSR_W-1:0];
  assign rem      = lfsr_d_r - LFSR_W'(quot * LFSR_W'(CAPACITY));

  assign victim_idx = victim_r;
  assign victim_key = keys_r[victim_r];
  assign victim_ok  = (settle_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      lfsr_r   <= LFSR_RESET;
      settle_r <= 2'd2;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (step) begin
        lfsr_r   <= lfsr_nxt;
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_r[wr_idx] <= wr_key;
    end
    prod_r   <= PROD_W'(lfsr_r) * PROD_W'(RECIP);
    lfsr_d_r <= lfsr_r;
    victim_r <= rem[IDX_W-1:0];
  end

endmodule

FILE: hw/rtl/ccpt_xlat.sv
module ccpt_xlat #(
  parameter int PAGE_SLOTS = 1024
) (
  input  logic                        clk,
  input  ccpt_pkg::xlat_ctl_t         ctl,
  input  logic [ccpt_pkg::KEY_W-1:0]  key,
  input  logic [ccpt_pkg::ES_W-1:0]   entry_size,
  input  logic [ccpt_pkg::BASE_W-1:0] icm_base,
  input  logic [31:0]                 map_vaddr,
  input  logic [63:0]                 map_paddr,
  output ccpt_pkg::xlat_stat_t        stat,
  output logic [63:0]                 paddr
);
  import ccpt_pkg::*;

  localparam int PT_AW = $clog2(PAGE_SLOTS);
  localparam int PG_W  = VA_W - PAGE_SHIFT;
  localparam int MPG_W = 32 - PAGE_SHIFT;

  logic [VA_W-1:0]       va_r;
  logic [PG_W-1:0]       page;
  logic [31:0]           moff;
  logic [MPG_W-1:0]      mpage;
  logic                  inr_r;
  logic [PAGE_SHIFT-1:0] off_r;
  logic [63:0]           pt_rdata;

  assign page  = va_r[VA_W-1:PAGE_SHIFT];
  assign moff  = map_vaddr - icm_base;
  assign mpage = moff[31:PAGE_SHIFT];

  assign stat.map_ok   = (21'(mpage) < 21'(PAGE_SLOTS));
  assign stat.in_range = inr_r;
  assign paddr         = pt_rdata + 64'(off_r);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      va_r <= VA_W'(key) * VA_W'(entry_size);
    end
    if (ctl.rd_en) begin
      inr_r <= (PG_W'(page) < PG_W'(PAGE_SLOTS));
      off_r <= va_r[PAGE_SHIFT-1:0] & OFF_MASK;
    end
  end

  ccpt_ram #(
    .WIDTH(64),
    .DEPTH(PAGE_SLOTS)
  ) u_pt (
    .clk  (clk),
    .we   (ctl.map_en && stat.map_ok),
    .waddr(mpage[PT_AW-1:0]),
    .wdata(map_paddr),
    .re   (ctl.rd_en),
    .raddr(page[PT_AW-1:0]),
    .rdata(pt_rdata)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ccpt_pkg::*;

  localparam int SLOTS = 16;
  localparam int PAGES = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_WORDS = 250;
  localparam int SETTLE = 12;

  typedef struct {
    req_type_t   typ;
    logic [23:0] key;
    logic [63:0] data;
    logic [7:0]  tag;
    logic [31:0] vaddr;
    logic [63:0] paddr;
    logic        mlast;
    int          ntyped;
    res_t        typed;
  } word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic [KEY_W-1:0] in_res_index;
  logic [DATA_W-1:0] in_entry_data;
  logic [TAG_W-1:0] in_req_tag;
  logic [31:0] in_icm_vaddr;
  logic [63:0] in_icm_paddr;
  logic in_map_last;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_res_kind;
  logic [63:0] out_res_addr;
  logic [DATA_W-1:0] out_res_data;
  logic [KEY_W-1:0] out_res_entry;
  logic [TAG_W-1:0] out_res_tag;
  logic out_last;

  context_cache_with_page_translation dut (.*);

  // cache and page table mirror
  logic        m_valid[SLOTS];
  logic [23:0] m_key[SLOTS];
  logic [63:0] m_data[SLOTS];
  logic [63:0] m_ptab[PAGES];
  bit          m_mapped[PAGES];
  logic        m_pend;
  logic [7:0]  m_ptag;
  logic [23:0] m_miss_key;
  logic [15:0] m_lfsr;
  logic [31:0] m_base;
  logic [12:0] m_esize;
  bit          quiet;

  res_t expected_q[$];
  int errors, n_words, n_results, n_evicts, cycles;
  int snd_pct, rcv_pct;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[context_cache_with_page_translation] ERROR");
      $finish;
    end
  end

  function automatic void push_res(logic [2:0] kind, logic [63:0] addr, logic [63:0] data,
                                   logic [23:0] entry, logic [7:0] tag, logic lst);
    res_t r;
    r.kind = kind; r.addr = addr; r.data = data;
    r.entry = entry; r.tag = tag; r.last = lst;
    if (kind == KIND_WB || (kind == KIND_RANGE && data != 0)) n_evicts++;
    if (!quiet) expected_q.push_back(r);
  endfunction

  function automatic int page_of(logic [23:0] key);
    logic [36:0] va;
    va = {13'd0, key} * {24'd0, m_esize};
    if ((va >> PAGE_SHIFT) >= PAGES) return -1;
    return int'(va >> PAGE_SHIFT);
  endfunction

  function automatic bit phys_addr(logic [23:0] key, output logic [63:0] pa);
    logic [36:0] va;
    int pg;
    va = {13'd0, key} * {24'd0, m_esize};
    pg = page_of(key);
    pa = 0;
    if (pg < 0) return 0;
    pa = m_ptab[pg] + {52'd0, va[11:0] & OFF_MASK};
    return 1;
  endfunction

  function automatic int lookup(logic [23:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void place_entry(logic [23:0] key, logic [63:0] data, logic lst);
    int v;
    logic [63:0] pa;
    for (int i = 0; i < SLOTS; i++) begin
      if (!m_valid[i]) begin
        m_valid[i] = 1; m_key[i] = key; m_data[i] = data;
        return;
      end
    end
    v = m_lfsr % SLOTS;
    m_lfsr = {m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5], m_lfsr[15:1]};
    if (phys_addr(m_key[v], pa)) push_res(KIND_WB, pa, m_data[v], m_key[v], 0, lst);
    else push_res(KIND_RANGE, 0, m_data[v], m_key[v], 0, lst);
    m_key[v] = key;
    m_data[v] = data;
  endfunction

  function automatic void predict_word(word_t w);
    int s;
    logic [63:0] pa;
    logic [31:0] off;
    case (w.typ)
      REQ_READ: begin
        s = lookup(w.key);
        if (m_pend) push_res(KIND_BUSY, 0, 0, w.key, w.tag, 1);
        else if (s >= 0) push_res(KIND_DATA, 0, m_data[s], w.key, w.tag, 1);
        else if (!phys_addr(w.key, pa)) push_res(KIND_RANGE, 0, 0, w.key, 0, 1);
        else begin
          m_pend = 1; m_ptag = w.tag; m_miss_key = w.key;
          push_res(KIND_DMA, pa, 0, w.key, w.tag, 1);
        end
      end
      REQ_WRITE: begin
        s = lookup(w.key);
        if (s >= 0) m_data[s] = w.data;
        else place_entry(w.key, w.data, 1);
      end
      REQ_FILL: begin
        if (m_pend) begin
          m_pend = 0;
          s = lookup(w.key);
          if (s >= 0) push_res(KIND_DATA, 0, m_data[s], w.key, m_ptag, 1);
          else begin
            place_entry(w.key, w.data, 0);
            push_res(KIND_DATA, 0, w.data, w.key, m_ptag, 1);
          end
        end
      end
      default: begin
        off = w.vaddr - m_base;
        if ((off >> PAGE_SHIFT) >= PAGES) push_res(KIND_RANGE, 0, 0, 0, 0, 1);
        else begin
          m_ptab[off >> PAGE_SHIFT] = w.paddr;
          m_mapped[off >> PAGE_SHIFT] = 1;
        end
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(word_t w);
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_req_type = w.typ;
    in_res_index = w.key;
    in_entry_data = w.data;
    in_req_tag = w.tag;
    in_icm_vaddr = w.vaddr;
    in_icm_paddr = w.paddr;
    in_map_last = w.mlast;
    do @(posedge clk); while (!in_ready);
    n_words++;
    quiet = (w.ntyped >= 0);
    predict_word(w);
    quiet = 0;
    if (w.ntyped == 1) expected_q.push_back(w.typed);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic word_t blank_word(req_type_t typ, logic [23:0] key);
    word_t w;
    w.typ = typ; w.key = key;
    w.data = {$urandom, $urandom}; w.tag = $urandom;
    w.vaddr = $urandom; w.paddr = {$urandom, $urandom};
    w.mlast = $urandom; w.ntyped = -1; w.typed = '0;
    return w;
  endfunction

  task automatic send_map_page(int pg);
    word_t w;
    w = blank_word(REQ_MAP, 0);
    w.vaddr = m_base + (pg << PAGE_SHIFT) + $urandom_range(0, 4095);
    send_word(w);
  endtask

  // keeps translations away from pages never loaded
  task automatic make_legal(logic [23:0] key);
    int pg;
    pg = page_of(key);
    if (pg >= 0 && !m_mapped[pg]) send_map_page(pg);
  endtask

  task automatic settle();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [31:0] val);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == CFG_ICM_BASE) m_base = val;
    else m_esize = val[12:0];
  endtask

  function automatic logic [23:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 40);
    if (r < 93) return $urandom;
    return $urandom_range(0, 4095);
  endfunction

  task automatic random_words(int count, bit hold);
    word_t w;
    int r;
    logic [23:0] key;
    for (int n = 0; n < count; n++) begin
      if (hold && n == count / 2)
        while (expected_q.size() != 0) @(negedge clk);
      r = $urandom_range(0, 99);
      key = pick_key();
      if (r < 12) begin
        w = blank_word(REQ_MAP, 0);
        if ($urandom_range(0, 9) < 7)
          w.vaddr = m_base + ($urandom_range(0, PAGES - 1) << PAGE_SHIFT) + $urandom_range(0, 4095);
        send_word(w);
        continue;
      end
      if (m_pend && r < 45) begin
        if ($urandom_range(0, 99) < 85) key = m_miss_key;
        w = blank_word(REQ_FILL, key);
      end else if (r < 70) w = blank_word(REQ_READ, key);
      else if (r < 85) w = blank_word(REQ_WRITE, key);
      else w = blank_word(REQ_FILL, key);
      make_legal(key);
      send_word(w);
    end
  endtask

  // receiver
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("unexpected word kind %0d entry %0h", out_res_kind, out_res_entry);
          errors++;
        end else begin
          res_t e;
          e = expected_q.pop_front();
          if (out_res_kind !== e.kind) begin
            $error("res_kind exp %0d got %0d", e.kind, out_res_kind); errors++;
          end
          if (out_res_addr !== e.addr) begin
            $error("res_addr exp %h got %h", e.addr, out_res_addr); errors++;
          end
          if (out_res_data !== e.data) begin
            $error("res_data exp %h got %h", e.data, out_res_data); errors++;
          end
          if (out_res_entry !== e.entry) begin
            $error("res_entry exp %h got %h", e.entry, out_res_entry); errors++;
          end
          if (out_res_tag !== e.tag) begin
            $error("res_tag exp %h got %h", e.tag, out_res_tag); errors++;
          end
          if (out_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_last); errors++;
          end
        end
      end
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  word_t directed[$];

  task automatic add_row(req_type_t typ, logic [23:0] key, logic [63:0] data, logic [7:0] tag,
                         logic [31:0] va, logic [63:0] pa, int ntyped, res_t typed);
    word_t w;
    w.typ = typ; w.key = key; w.data = data; w.tag = tag;
    w.vaddr = va; w.paddr = pa; w.mlast = tag[0];
    w.ntyped = ntyped; w.typed = typed;
    directed.push_back(w);
  endtask

  initial begin
    res_t none;
    none = '0;
    errors = 0; n_words = 0; n_results = 0; n_evicts = 0; cycles = 0;
    snd_pct = 0; rcv_pct = 0; quiet = 0;
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_req_type = 0; in_res_index = 0; in_entry_data = 0;
    in_req_tag = 0; in_icm_vaddr = 0; in_icm_paddr = 0; in_map_last = 0;
    for (int i = 0; i < SLOTS; i++) begin
      m_valid[i] = 0; m_key[i] = 0; m_data[i] = 0;
    end
    for (int i = 0; i < PAGES; i++) begin
      m_ptab[i] = 0; m_mapped[i] = 0;
    end
    m_pend = 0; m_ptag = 0; m_miss_key = 0; m_lfsr = LFSR_RESET;
    m_base = 0; m_esize = ENTRY_SIZE_RESET;
    repeat (11) @(negedge clk);
    rst_n = 1;

    add_row(REQ_MAP, 0, 0, 8'h00, 32'h0, 64'hFFFF_FFFF_FFFF_F000, 0, none);
    add_row(REQ_MAP, 0, 0, 8'h01, 32'hFFFF_FFFF, 64'h0, 1, '{KIND_RANGE, 0, 0, 0, 0, 1});
    add_row(REQ_READ, 24'hFFFFFF, 0, 8'hFF, 0, 0, 1,
            '{KIND_RANGE, 0, 0, 24'hFFFFFF, 0, 1});
    add_row(REQ_READ, 1, 0, 8'h5A, 0, 0, -1, none);
    add_row(REQ_READ, 2, 0, 8'h33, 0, 0, 1, '{KIND_BUSY, 0, 0, 2, 8'h33, 1});
    add_row(REQ_FILL, 1, '1, 8'h00, 0, 0, -1, none);
    add_row(REQ_FILL, 3, 64'h1, 8'h00, 0, 0, 0, none);
    add_row(REQ_READ, 1, 0, 8'h00, 0, 0, -1, none);
    add_row(REQ_WRITE, 1, 0, 8'h00, 0, 0, 0, none);
    add_row(REQ_READ, 1, 0, 8'hC3, 0, 0, -1, none);
    add_row(REQ_READ, 5, 0, 8'h01, 0, 0, -1, none);
    add_row(REQ_WRITE, 5, 64'h1234, 8'h00, 0, 0, 0, none);
    add_row(REQ_FILL, 5, 64'h5555_AAAA_5555_AAAA, 8'h00, 0, 0, -1, none);
    add_row(REQ_WRITE, 24'hFFFFFF, 64'hAAAA_5555_AAAA_5555, 8'h00, 0, 0, 0, none);
    for (int k = 6; k < 15; k++)
      add_row(REQ_WRITE, k, {$urandom, $urandom}, 8'h00, 0, 0, 0, none);
    add_row(REQ_READ, 24'h00003F, 0, 8'h80, 0, 0, -1, none);
    add_row(REQ_FILL, 24'h00003F, 64'h8000_0000_0000_0001, 8'h00, 0, 0, -1, none);
    foreach (directed[i]) send_word(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      snd_pct = (ph == 0) ? 28 : (ph == 1) ? 76 : 0;
      rcv_pct = (ph == 0) ? 76 : (ph == 1) ? 28 : 0;
      case (ph)
        0: begin write_cfg(CFG_ICM_BASE, 32'h0); write_cfg(CFG_ENTRY_SIZE, 32'd1); end
        1: begin write_cfg(CFG_ICM_BASE, 32'hFFFF_FFFF); write_cfg(CFG_ENTRY_SIZE, 32'd4096); end
        2: begin write_cfg(CFG_ICM_BASE, $urandom); write_cfg(CFG_ENTRY_SIZE, 32'd64); end
        default: begin
          write_cfg(CFG_ICM_BASE, $urandom);
          write_cfg(CFG_ENTRY_SIZE, $urandom_range(1, 4096));
        end
      endcase
      for (int i = 0; i < SLOTS; i++)
        if (m_valid[i]) make_legal(m_key[i]);
      random_words(PHASE_WORDS, ph == 1);
    end

    settle();
    $display("%0d words sent over four register settings and three flow patterns,",
             n_words);
    $display("%0d results checked, %0d of them evictions", n_results, n_evicts);
    if (errors == 0) begin
      $display("[context_cache_with_page_translation] OK");
    end else begin
      $display("[context_cache_with_page_translation] ERROR");
    end
    $finish;
  end

endmodule
